// ===== hdl/rlbd_pkg.sv =====
// Shared constants, codes and types for the resistor-ladder button debouncer.
package rlbd_pkg;

  localparam int LEVEL_W      = 10;
  localparam int FILTER_SHIFT = 3;
  localparam int ACC_W        = LEVEL_W + FILTER_SHIFT;
  localparam int ELAPSED_W    = 17;
  localparam int DELAY_W      = 16;
  localparam int STATE_W      = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int DEBOUNCE_US  = 5000;
  localparam int US_PER_TICK  = 100;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
  localparam logic [ACC_W-1:0]   ACC_RESET = {LEVEL_MAX, {FILTER_SHIFT{1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 2'd2;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [STATE_W-1:0] {
    ST_UP       = 2'd0,
    ST_DEBOUNCE = 2'd1,
    ST_PRESSED  = 2'd2
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] press_threshold;
    logic [LEVEL_W-1:0] release_threshold;
    logic [DELAY_W-1:0] repeat_delay_us;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic clear;
  } step_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] button_value;
    logic [STATE_W-1:0] press_state;
  } ctrl_out_t;

endpackage

// ===== hdl/rlbd_ifs.sv =====
// Handshake channel interfaces: request, response and register write.
interface rlbd_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [rlbd_pkg::LEVEL_W-1:0] adc_sample;
  modport source (output valid, req_type, adc_sample, input ready);
  modport sink (input valid, req_type, adc_sample, output ready);
endinterface

interface rlbd_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rlbd_pkg::LEVEL_W-1:0] button_value;
  logic [rlbd_pkg::LEVEL_W-1:0] filtered_level;
  logic [rlbd_pkg::STATE_W-1:0] press_state;
  modport source (output valid, button_value, filtered_level, press_state, input ready);
  modport sink (input valid, button_value, filtered_level, press_state, output ready);
endinterface

interface rlbd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rlbd_pkg::CFG_IDX_W-1:0]  index;
  logic [rlbd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/resistor_ladder_button_debouncer_top.sv =====
// Top level of the resistor-ladder button debouncer.
// One request is taken per clock while rsp does not stall: a sample tick runs the
// leaky-integrator filter and the press state machine, a read returns the held
// value and clears it. A transfer on req lands in an input register; when the
// output register is free or being taken, the filter and state machine update in
// one step and the result lands in the output register, so the block sustains
// one item per cycle while responses are taken without stall.
// While a response waits, the input register takes one more request and req then
// stalls until that response is taken. Registers on cfg are always ready and take
// effect for the next request.
module resistor_ladder_button_debouncer_top (
  input logic        clk,
  input logic        rst,
  rlbd_req_if.sink   req,
  rlbd_rsp_if.source rsp,
  rlbd_cfg_if.sink   cfg
);
  import rlbd_pkg::*;

  cfg_t               regs;
  step_t              step;
  ctrl_out_t          ctrl_res;
  logic [LEVEL_W-1:0] cur_level;
  logic [LEVEL_W-1:0] step_level;

  logic               stg_valid;
  logic               stg_req_type;
  logic [LEVEL_W-1:0] stg_sample;
  logic               advance;

  logic               res_valid;
  logic [LEVEL_W-1:0] res_button_value;
  logic [LEVEL_W-1:0] res_filtered_level;
  logic [STATE_W-1:0] res_press_state;

  assign advance    = stg_valid && (!res_valid || rsp.ready);
  assign req.ready  = !stg_valid || advance;
  assign step.tick  = advance && (stg_req_type == REQ_TICK);
  assign step.clear = advance && (stg_req_type == REQ_READ);

  rlbd_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rlbd_filter u_filter (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .sample     (stg_sample),
    .cur_level  (cur_level),
    .step_level (step_level)
  );

  rlbd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .level (step_level),
    .regs  (regs),
    .res   (ctrl_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      stg_valid <= (req.valid && req.ready) || (stg_valid && !advance);
      res_valid <= advance || (res_valid && !rsp.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stg_req_type <= req.req_type;
      stg_sample   <= req.adc_sample;
    end
    if (advance) begin
      res_button_value   <= ctrl_res.button_value;
      res_filtered_level <= step_level;
      res_press_state    <= ctrl_res.press_state;
    end
  end

  assign rsp.valid          = res_valid;
  assign rsp.button_value   = res_button_value;
  assign rsp.filtered_level = res_filtered_level;
  assign rsp.press_state    = res_press_state;

  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("result register not loaded after stage advance");

  a_read_keeps_filter: assert property (@(posedge clk) disable iff (rst)
    step.clear |=> $stable(cur_level))
    else $error("filter moved on a read request");

  a_read_reports_level: assert property (@(posedge clk) disable iff (rst)
    step.clear |=> rsp.filtered_level == $past(cur_level))
    else $error("read response carries wrong filtered level");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !stg_valid |-> req.ready)
    else $error("request refused while input register empty");

endmodule

// ===== hdl/rlbd_cfg.sv =====
// Configuration registers: thresholds and auto-repeat delay.
module rlbd_cfg (
  input  logic            clk,
  input  logic            rst,
  rlbd_cfg_if.sink        cfg,
  output rlbd_pkg::cfg_t  regs
);
  import rlbd_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.press_threshold   <= '0;
      regs.release_threshold <= LEVEL_MAX;
      regs.repeat_delay_us   <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PRESS_THR:    regs.press_threshold   <= cfg.data[LEVEL_W-1:0];
        REG_RELEASE_THR:  regs.release_threshold <= cfg.data[LEVEL_W-1:0];
        REG_REPEAT_DELAY: regs.repeat_delay_us   <= cfg.data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/rlbd_filter.sv =====
// Leaky-integrator smoothing filter over the ADC samples.
module rlbd_filter (
  input  logic                         clk,
  input  logic                         rst,
  input  rlbd_pkg::step_t              step,
  input  logic [rlbd_pkg::LEVEL_W-1:0] sample,
  output logic [rlbd_pkg::LEVEL_W-1:0] cur_level,
  output logic [rlbd_pkg::LEVEL_W-1:0] step_level
);
  import rlbd_pkg::*;

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;

  always_comb begin
    acc_next = acc;
    if (step.tick) begin
      acc_next = acc - (acc >> FILTER_SHIFT) + ACC_W'(sample);
    end
  end

  assign cur_level  = acc[ACC_W-1:FILTER_SHIFT];
  assign step_level = acc_next[ACC_W-1:FILTER_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= ACC_RESET;
    end else begin
      acc <= acc_next;
    end
  end

endmodule

// ===== hdl/rlbd_ctrl.sv =====
// Press state machine with debounce timer, auto-repeat and held value.
module rlbd_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  rlbd_pkg::step_t              step,
  input  logic [rlbd_pkg::LEVEL_W-1:0] level,
  input  rlbd_pkg::cfg_t               regs,
  output rlbd_pkg::ctrl_out_t          res
);
  import rlbd_pkg::*;

  localparam logic [ELAPSED_W-1:0] DEBOUNCE_LIM = ELAPSED_W'(DEBOUNCE_US);
  localparam logic [ELAPSED_W-1:0] TICK_US      = ELAPSED_W'(US_PER_TICK);

  state_t               state;
  state_t               state_next;
  logic [ELAPSED_W-1:0] elapsed;
  logic [ELAPSED_W-1:0] elapsed_next;
  logic [LEVEL_W-1:0]   pressed_level;
  logic [LEVEL_W-1:0]   pressed_level_next;
  logic [LEVEL_W-1:0]   held_value;
  logic [LEVEL_W-1:0]   held_value_next;

  always_comb begin
    state_next         = state;
    elapsed_next       = elapsed;
    pressed_level_next = pressed_level;
    held_value_next    = held_value;
    if (step.clear) begin
      held_value_next = LEVEL_MAX;
    end else if (step.tick) begin
      unique case (state)
        ST_DEBOUNCE: begin
          if (elapsed < DEBOUNCE_LIM) begin
            elapsed_next = elapsed + TICK_US;
          end else begin
            pressed_level_next = level;
            held_value_next    = level;
            elapsed_next       = '0;
            state_next         = ST_PRESSED;
          end
        end
        ST_PRESSED: begin
          if (level >= regs.release_threshold) begin
            state_next = ST_UP;
          end else if (regs.repeat_delay_us != '0) begin
            if (elapsed < ELAPSED_W'(regs.repeat_delay_us)) begin
              elapsed_next = elapsed + TICK_US;
            end else begin
              held_value_next = pressed_level;
              elapsed_next    = '0;
            end
          end
        end
        default: begin
          if (level <= regs.press_threshold) begin
            elapsed_next = '0;
            state_next   = ST_DEBOUNCE;
          end
        end
      endcase
    end
    res.button_value = step.clear ? held_value : held_value_next;
    res.press_state  = state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_UP;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed       <= '0;
      pressed_level <= '0;
      held_value    <= LEVEL_MAX;
    end else begin
      elapsed       <= elapsed_next;
      pressed_level <= pressed_level_next;
      held_value    <= held_value_next;
    end
  end

endmodule

// ===== verif/rlbd_reading_check.sv =====
// Checker for the button debouncer: predicts every response and compares it field by field.
`timescale 1ns / 100ps

module rlbd_reading_check (
  input  logic clk,
  input  logic rst,
  rlbd_req_if  req,
  rlbd_rsp_if  rsp,
  rlbd_cfg_if  cfg,
  output int   pending,
  output int   failures
);
  import rlbd_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0] button_value;
    logic [LEVEL_W-1:0] filtered_level;
    logic [STATE_W-1:0] press_state;
  } reading_t;

  reading_t reading_q[$];

  logic [LEVEL_W-1:0]   press_thr;
  logic [LEVEL_W-1:0]   release_thr;
  logic [DELAY_W-1:0]   repeat_delay;
  logic [ACC_W-1:0]     accum;
  state_t               phase;
  logic [ELAPSED_W-1:0] elapsed_us;
  logic [LEVEL_W-1:0]   latched_level;
  logic [LEVEL_W-1:0]   held_level;

  function automatic int field_miss(string name, int want, int got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  task automatic predict_reading(input logic kind, input logic [LEVEL_W-1:0] sample);
    logic [LEVEL_W-1:0] level;
    reading_t           want;
    if (kind == REQ_READ) begin
      want.button_value = held_level;
      held_level = LEVEL_MAX;
    end else begin
      accum = accum - (accum >> FILTER_SHIFT) + ACC_W'(sample);
      level = accum[ACC_W-1:FILTER_SHIFT];
      case (phase)
        ST_DEBOUNCE: begin
          if (elapsed_us < ELAPSED_W'(DEBOUNCE_US)) begin
            elapsed_us = ELAPSED_W'(elapsed_us + US_PER_TICK);
          end else begin
            latched_level = level;
            held_level    = level;
            elapsed_us    = '0;
            phase         = ST_PRESSED;
          end
        end
        ST_PRESSED: begin
          if (level >= release_thr) begin
            phase = ST_UP;
          end else if (repeat_delay != '0) begin
            if (elapsed_us < ELAPSED_W'(repeat_delay)) begin
              elapsed_us = ELAPSED_W'(elapsed_us + US_PER_TICK);
            end else begin
              held_level = latched_level;
              elapsed_us = '0;
            end
          end
        end
        default: begin
          if (level <= press_thr) begin
            elapsed_us = '0;
            phase      = ST_DEBOUNCE;
          end
        end
      endcase
      want.button_value = held_level;
    end
    want.filtered_level = accum[ACC_W-1:FILTER_SHIFT];
    want.press_state    = phase;
    reading_q.push_back(want);
  endtask

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    int       miss;
    miss = 0;
    if (rst) begin
      press_thr     = '0;
      release_thr   = LEVEL_MAX;
      repeat_delay  = '0;
      accum         = ACC_RESET;
      phase         = ST_UP;
      elapsed_us    = '0;
      latched_level = '0;
      held_level    = LEVEL_MAX;
      reading_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PRESS_THR:    press_thr    = cfg.data[LEVEL_W-1:0];
          REG_RELEASE_THR:  release_thr  = cfg.data[LEVEL_W-1:0];
          REG_REPEAT_DELAY: repeat_delay = cfg.data[DELAY_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        got.button_value   = rsp.button_value;
        got.filtered_level = rsp.filtered_level;
        got.press_state    = rsp.press_state;
        if (reading_q.size() == 0) begin
          $error("unexpected response: button_value %0d, filtered_level %0d, press_state %0d",
                 got.button_value, got.filtered_level, got.press_state);
          miss = 1;
        end else begin
          want = reading_q.pop_front();
          miss += field_miss("button_value", want.button_value, got.button_value);
          miss += field_miss("filtered_level", want.filtered_level, got.filtered_level);
          miss += field_miss("press_state", want.press_state, got.press_state);
        end
      end
      if (req.valid && req.ready) predict_reading(req.req_type, req.adc_sample);
    end
    pending  <= reading_q.size();
    failures <= rst ? 0 : failures + miss;
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the button debouncer: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_top;
  import rlbd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int MAX_WAIT       = 14;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   quiet_req;
  bit   quiet_rsp;
  int   items_sent;
  int   quiet_cycles;
  int   pending;
  int   failures;

  rlbd_req_if req_ch();
  rlbd_rsp_if rsp_ch();
  rlbd_cfg_if cfg_ch();

  resistor_ladder_button_debouncer_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  rlbd_reading_check reading_check (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg      (cfg_ch),
    .pending  (pending),
    .failures (failures)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = quiet_rsp ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  task automatic send_item(input logic kind, input logic [LEVEL_W-1:0] sample);
    int gap;
    gap = quiet_req ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.adc_sample <= sample;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_config(input logic [LEVEL_W-1:0] press_lvl,
                            input logic [LEVEL_W-1:0] release_lvl,
                            input logic [DELAY_W-1:0] delay);
    write_reg(REG_PRESS_THR, {(CFG_DATA_W-LEVEL_W)'($urandom), press_lvl});
    write_reg(REG_RELEASE_THR, {(CFG_DATA_W-LEVEL_W)'($urandom), release_lvl});
    write_reg(REG_REPEAT_DELAY, delay);
    if ($urandom_range(0, 1) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic hold_level(input int level, input int noise, input int count);
    int v;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(REQ_READ, LEVEL_W'($urandom));
      end else begin
        v = level + int'($urandom_range(0, 2 * noise)) - noise;
        if (v < 0) v = 0;
        else if (v > int'(LEVEL_MAX)) v = int'(LEVEL_MAX);
        send_item(REQ_TICK, LEVEL_W'(v));
      end
    end
  endtask

  initial begin
    int                 phase_no;
    int                 phase_end;
    bit                 squeezed;
    logic [LEVEL_W-1:0] press_lvl;
    logic [LEVEL_W-1:0] release_lvl;
    logic [DELAY_W-1:0] delay;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_TICK;
    req_ch.adc_sample = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_PRESS_THR;
    cfg_ch.data       = '0;
    quiet_req         = 1'b0;
    quiet_rsp         = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_item(REQ_READ, '0);
    send_item(REQ_READ, LEVEL_MAX);
    send_item(REQ_TICK, '0);
    send_item(REQ_TICK, LEVEL_MAX);
    send_item(REQ_TICK, 10'h2AA);
    send_item(REQ_TICK, 10'h155);
    send_item(REQ_READ, 10'h2AA);
    send_item(REQ_TICK, '0);
    drain();
    write_reg(REG_PRESS_THR, '1);
    write_reg(REG_RELEASE_THR, '0);
    write_reg(REG_REPEAT_DELAY, DELAY_W'(1));
    write_reg(REG_UNUSED, '1);
    cfg_ch.valid <= 1'b0;
    send_item(REQ_TICK, LEVEL_MAX);
    send_item(REQ_READ, '0);
    send_item(REQ_TICK, '0);
    send_item(REQ_TICK, 10'h200);
    send_item(REQ_READ, LEVEL_MAX);
    send_item(REQ_READ, '0);
    send_item(REQ_TICK, LEVEL_MAX);

    phase_no = 0;
    squeezed = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      case (phase_no)
        0: begin
          press_lvl = '0; release_lvl = LEVEL_MAX; delay = '1;
        end
        1: begin
          press_lvl = LEVEL_MAX; release_lvl = '0; delay = DELAY_W'(US_PER_TICK);
        end
        2: begin
          press_lvl = LEVEL_MAX; release_lvl = LEVEL_MAX; delay = DELAY_W'(1);
        end
        default: begin
          press_lvl   = LEVEL_W'($urandom_range(100, 700));
          release_lvl = LEVEL_W'($urandom_range(press_lvl + 1, LEVEL_MAX));
          case ($urandom_range(0, 3))
            0: delay = '0;
            1: delay = DELAY_W'($urandom_range(1, 20) * US_PER_TICK);
            2: delay = DELAY_W'($urandom_range(1, 2500));
            default: delay = DELAY_W'($urandom);
          endcase
        end
      endcase
      set_config(press_lvl, release_lvl, delay);
      quiet_req = ($urandom_range(0, 3) == 0);
      quiet_rsp = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + $urandom_range(100, 160);
      while (items_sent < phase_end) begin
        hold_level($urandom_range(0, press_lvl - press_lvl / 4), $urandom_range(0, press_lvl / 8),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : $urandom_range(70, 180));
        if (!squeezed || $urandom_range(0, 5) == 0) begin
          drain();
          squeezed = 1'b1;
        end
        hold_level($urandom_range(release_lvl, LEVEL_MAX),
                   ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 20),
                   $urandom_range(5, 40));
        repeat ($urandom_range(0, 6)) send_item(logic'($urandom_range(0, 1)), LEVEL_W'($urandom));
      end
      phase_no++;
    end

    drain();
    repeat (4) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
